// ===== design/bcpc_pkg.sv =====
// shared types and constants for the bone chain pose composer
`timescale 1ns / 1ps
package bcpc_pkg;
  localparam int Bones    = 64;
  localparam int MaxDepth = 16;
  localparam int IdxW     = $clog2(Bones);
  localparam int DepW     = $clog2(MaxDepth + 1);
  localparam int SpW      = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int QShift   = 14;
  localparam logic signed [15:0] QOne = 16'sd16384;

  typedef enum logic [1:0] {
    OP_ROT  = 2'd0,  // rotate offset, add to position
    OP_HAM  = 2'd1,  // hamilton product into rotation
    OP_INIT = 2'd2   // load identity
  } dp_op_t;

  typedef struct packed {
    logic   start;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  // product of q2.14 with signed value, floor shift by 14, kept at 48 bits
  function automatic logic signed [47:0] qmul(input logic signed [15:0] a,
                                              input logic signed [31:0] b);
    logic signed [47:0] p;
    p = 48'(a) * 48'(b);
    return p >>> QShift;
  endfunction
endpackage

// ===== design/bcpc_datapath.sv =====
// pose datapath: shared multiplier stepping through rotate and hamilton terms
`timescale 1ns / 1ps
module bcpc_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bcpc_pkg::dp_cmd_t        cmd,
  output bcpc_pkg::dp_sts_t        sts,
  input  logic signed [31:0]       off_x,
  input  logic signed [31:0]       off_y,
  input  logic signed [31:0]       off_z,
  input  logic signed [15:0]       lt_x,
  input  logic signed [15:0]       lt_y,
  input  logic signed [15:0]       lt_z,
  input  logic signed [15:0]       lt_w,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic signed [31:0]       pos_z,
  output logic signed [15:0]       rot_x,
  output logic signed [15:0]       rot_y,
  output logic signed [15:0]       rot_z,
  output logic signed [15:0]       rot_w
);
  // phase: rotate 0..5 first cross, 6..11 second cross, 12..14 w*t
  //        hamilton 0..15 terms
  logic [4:0] ph_r, ph_nxt;
  logic busy_r, busy_nxt;
  bcpc_pkg::dp_cmd_t lat_r;
  logic signed [31:0] p_r [3];
  logic signed [15:0] q_r [4];
  logic signed [31:0] t_r [3];
  logic signed [31:0] c_r [3];
  logic signed [15:0] h_r [4];
  logic signed [15:0] ma;
  logic signed [31:0] mb;
  logic signed [47:0] prod;
  logic sub;
  logic [1:0] dst;
  logic signed [31:0] vin [3];
  logic last;

  assign vin[0] = off_x; assign vin[1] = off_y; assign vin[2] = off_z;

  function automatic logic [1:0] nx(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction
  function automatic logic [1:0] nx2(input logic [1:0] k);
    return (k == 2'd0) ? 2'd2 : k - 2'd1;
  endfunction

  // term selection
  always_comb begin
    logic [1:0] k;
    logic [4:0] j;
    logic [1:0] bs;
    logic signed [15:0] ta [4];
    logic signed [15:0] tb [4];
    ma = '0; mb = '0; sub = 1'b0; dst = '0; k = '0; j = '0; bs = '0;
    ta[0]=q_r[3]; ta[1]=q_r[0]; ta[2]=q_r[1]; ta[3]=q_r[2];
    tb[0]=lt_x; tb[1]=lt_y; tb[2]=lt_z; tb[3]=lt_w;
    if (lat_r.op == bcpc_pkg::OP_ROT) begin
      if (ph_r < 5'd12) begin
        j = (ph_r < 5'd6) ? ph_r : ph_r - 5'd6;
        k = j[2:1];
        dst = k;
        sub = j[0];
        // r[k] = u[k+1]*v[k+2] - u[k+2]*v[k+1]
        ma = q_r[j[0] ? nx2(k) : nx(k)];
        mb = (ph_r < 5'd6) ? vin[j[0] ? nx(k) : nx2(k)] : t_r[j[0] ? nx(k) : nx2(k)];
      end else begin
        dst = 2'(ph_r - 5'd12);
        ma = q_r[3];
        mb = t_r[dst];
      end
    end else begin
      // component ph[3:2], term ph[1:0]: ordering a_w, a_x, a_y, a_z
      dst = ph_r[3:2];
      unique case (ph_r[3:2])
        2'd0: begin
          bs = (ph_r[1:0] == 2'd0) ? 2'd0 : (ph_r[1:0] == 2'd1) ? 2'd3 :
               (ph_r[1:0] == 2'd2) ? 2'd2 : 2'd1;
          sub = (ph_r[1:0] == 2'd3);
        end
        2'd1: begin
          bs = (ph_r[1:0] == 2'd0) ? 2'd1 : (ph_r[1:0] == 2'd1) ? 2'd2 :
               (ph_r[1:0] == 2'd2) ? 2'd3 : 2'd0;
          sub = (ph_r[1:0] == 2'd1);
        end
        2'd2: begin
          bs = (ph_r[1:0] == 2'd0) ? 2'd2 : (ph_r[1:0] == 2'd1) ? 2'd1 :
               (ph_r[1:0] == 2'd2) ? 2'd0 : 2'd3;
          sub = (ph_r[1:0] == 2'd2);
        end
        default: begin
          bs = (ph_r[1:0] == 2'd0) ? 2'd3 : (ph_r[1:0] == 2'd1) ? 2'd0 :
               (ph_r[1:0] == 2'd2) ? 2'd1 : 2'd2;
          sub = (ph_r[1:0] != 2'd0);
        end
      endcase
      mb = 32'(tb[bs]);
      ma = ta[ph_r[1:0]];
    end
  end

  assign prod = bcpc_pkg::qmul(ma, mb);
  assign last = (lat_r.op == bcpc_pkg::OP_ROT) ? (ph_r == 5'd14) : (ph_r == 5'd15);

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt = ph_r;
    if (cmd.start && cmd.op != bcpc_pkg::OP_INIT) begin
      busy_nxt = 1'b1; ph_nxt = '0;
    end else if (busy_r) begin
      ph_nxt = ph_r + 5'd1;
      if (last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      lat_r  <= '{start: 1'b0, op: bcpc_pkg::OP_INIT};
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      if (cmd.start) lat_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && cmd.op == bcpc_pkg::OP_INIT) begin
      for (int i = 0; i < 3; i++) p_r[i] <= '0;
      q_r[0] <= '0; q_r[1] <= '0; q_r[2] <= '0; q_r[3] <= bcpc_pkg::QOne;
    end else if (cmd.start) begin
      for (int i = 0; i < 3; i++) c_r[i] <= '0;
      for (int i = 0; i < 4; i++) h_r[i] <= '0;
    end else if (busy_r) begin
      if (lat_r.op == bcpc_pkg::OP_ROT) begin
        if (ph_r < 5'd6) begin
          if (ph_r[0]) t_r[dst] <= 32'(c_r[dst] - 32'(prod)) <<< 1;
          else c_r[dst] <= 32'(prod);
        end else if (ph_r < 5'd12) begin
          if (ph_r[0]) c_r[dst] <= 32'(c_r[dst] - 32'(prod));
          else c_r[dst] <= 32'(prod);
        end else begin
          p_r[dst] <= p_r[dst] + vin[dst] + 32'(prod) + c_r[dst];
        end
      end else begin
        // all four components accumulate in h, rotation updated at the end
        if (last) begin
          q_r[0] <= h_r[0];
          q_r[1] <= h_r[1];
          q_r[2] <= h_r[2];
          q_r[3] <= h_r[3] - 16'(prod);
        end else begin
          h_r[dst] <= h_r[dst] + (sub ? -16'(prod) : 16'(prod));
        end
      end
    end
  end

  assign sts.done = busy_r && last;
  assign pos_x = p_r[0]; assign pos_y = p_r[1]; assign pos_z = p_r[2];
  assign rot_x = q_r[0]; assign rot_y = q_r[1]; assign rot_z = q_r[2];
  assign rot_w = q_r[3];
endmodule

// ===== design/bcpc_ctrl.sv =====
// controller: bone table, chain gather and compose sequencing
`timescale 1ns / 1ps
module bcpc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          in_query,
  input  logic [bcpc_pkg::IdxW-1:0]     in_bone,
  input  logic [bcpc_pkg::IdxW-1:0]     in_parent,
  input  logic                          in_root,
  input  logic [95:0]                   in_off,
  input  logic [63:0]                   in_turn,
  output logic                          ready,
  output logic                          res_valid,
  input  logic                          res_taken,
  output bcpc_pkg::dp_cmd_t             cmd,
  input  bcpc_pkg::dp_sts_t             sts,
  output logic [95:0]                   cur_off,
  output logic [63:0]                   cur_turn
);
  typedef enum logic [2:0] {S_IDLE, S_GRD, S_GATH, S_LOAD, S_ROT, S_HAM, S_OUT} st_t;
  st_t st_r;
  logic [bcpc_pkg::IdxW:0]   par_mem [bcpc_pkg::Bones];
  logic [95:0]               off_mem [bcpc_pkg::Bones];
  logic [63:0]               trn_mem [bcpc_pkg::Bones];
  logic [bcpc_pkg::IdxW-1:0] stk_r [bcpc_pkg::MaxDepth];
  logic [bcpc_pkg::IdxW:0]   par_rd_r;
  logic [bcpc_pkg::IdxW-1:0] idx_r;
  logic [bcpc_pkg::DepW-1:0] dep_r;
  bcpc_pkg::dp_cmd_t         cmd_r;

  always_ff @(posedge clk) begin
    if (in_fire && !in_query) begin
      par_mem[in_bone] <= {in_root, in_parent};
      off_mem[in_bone] <= in_off;
      trn_mem[in_bone] <= in_turn;
    end
    par_rd_r <= par_mem[idx_r];
    cur_off  <= off_mem[idx_r];
    cur_turn <= trn_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      dep_r <= '0;
      idx_r <= '0;
      cmd_r <= '{start: 1'b0, op: bcpc_pkg::OP_INIT};
    end else begin
      unique case (st_r)
        S_IDLE: if (in_fire && in_query) begin
          idx_r <= in_bone; dep_r <= '0; st_r <= S_GRD;
          cmd_r <= '{start: 1'b1, op: bcpc_pkg::OP_INIT};
        end else begin
          cmd_r.start <= 1'b0;
        end
        S_GRD: begin
          cmd_r.start <= 1'b0;
          stk_r[dep_r[bcpc_pkg::SpW-1:0]] <= idx_r;
          dep_r <= dep_r + 1'b1;
          st_r <= S_GATH;
        end
        S_GATH: begin
          cmd_r.start <= 1'b0;
          if (par_rd_r[bcpc_pkg::IdxW] ||
              dep_r == bcpc_pkg::DepW'(bcpc_pkg::MaxDepth)) begin
            idx_r <= stk_r[bcpc_pkg::SpW'(dep_r - 1'b1)];
            st_r <= S_LOAD;
          end else begin
            idx_r <= par_rd_r[bcpc_pkg::IdxW-1:0];
            st_r <= S_GRD;
          end
        end
        S_LOAD: begin
          cmd_r <= '{start: 1'b1, op: bcpc_pkg::OP_ROT};
          st_r <= S_ROT;
        end
        S_ROT: if (sts.done) begin
          cmd_r <= '{start: 1'b1, op: bcpc_pkg::OP_HAM};
          st_r <= S_HAM;
        end else begin
          cmd_r.start <= 1'b0;
        end
        S_HAM: begin
          cmd_r.start <= 1'b0;
          if (sts.done) begin
            dep_r <= dep_r - 1'b1;
            if (dep_r == bcpc_pkg::DepW'(1)) st_r <= S_OUT;
            else begin
              idx_r <= stk_r[bcpc_pkg::SpW'(dep_r - 2'd2)];
              st_r <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          cmd_r.start <= 1'b0;
          if (res_taken) st_r <= S_IDLE;
        end
        default: begin
          cmd_r.start <= 1'b0;
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd = cmd_r;
  assign ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
endmodule

// ===== design/bone_chain_pose_composer.sv =====
// top level of the bone chain pose composer
`timescale 1ns / 1ps
// A write request stores one bone (parent or root mark, Q16.16 offset, Q2.14
// rotation) and gives no result. A query request walks the parent chain
// (through the table read port) up to 16 bones, then composes root to bone on
// one shared 16x32 multiplier: for each bone a load step, then the offset
// rotation and then the hamilton product, each opened by its start command.
// One request in flight. Bone table contents are undefined until written.
module bone_chain_pose_composer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action
  input  logic         in_tuser,
  // bone_index, parent_index, is_root, offset_x/y/z, turn_x/y/z/w
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pose_x, pose_y, pose_z, orient_x, orient_y, orient_z, orient_w
  output logic [159:0] out_tdata
);
  logic in_fire;
  bcpc_pkg::dp_cmd_t cmd;
  bcpc_pkg::dp_sts_t sts;
  logic [95:0] cur_off;
  logic [63:0] cur_turn;
  logic signed [31:0] px, py, pz;
  logic signed [15:0] rx, ry, rz, rw;

  assign in_fire = in_tvalid && in_tready;

  bcpc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_query (in_tuser),
    .in_bone  (in_tdata[5:0]),
    .in_parent(in_tdata[11:6]),
    .in_root  (in_tdata[12]),
    .in_off   (in_tdata[108:13]),
    .in_turn  (in_tdata[172:109]),
    .ready    (in_tready),
    .res_valid(out_tvalid),
    .res_taken(out_tready),
    .cmd, .sts, .cur_off, .cur_turn
  );

  bcpc_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .off_x(cur_off[31:0]), .off_y(cur_off[63:32]), .off_z(cur_off[95:64]),
    .lt_x(cur_turn[15:0]), .lt_y(cur_turn[31:16]),
    .lt_z(cur_turn[47:32]), .lt_w(cur_turn[63:48]),
    .pos_x(px), .pos_y(py), .pos_z(pz),
    .rot_x(rx), .rot_y(ry), .rot_z(rz), .rot_w(rw)
  );

  assign out_tdata = {rw, rz, ry, rx, pz, py, px};

  // a result only appears when no request is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready)) else $error("result while accepting");
  // result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
endmodule
